### src/finder_candidate_merge_table_macros.svh
// Assertion shorthands shared by the table RTL.
// All properties sample on i_clk and are switched off while i_rst_n is low.
`ifndef FINDER_CANDIDATE_MERGE_TABLE_MACROS_SVH
`define FINDER_CANDIDATE_MERGE_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FCMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/fcmt_pkg.sv
package fcmt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int COORD_BITS  = 12;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // Fixed result field widths
    localparam int HITS_W = 16;
    localparam int SLOT_W = 4;
    localparam int OCC_W  = 5;
    localparam int THR_W  = 16;

    // Fixed-point scaling of sizes: (size << FRAC_BITS) / SIZE_DIV
    localparam int FRAC_BITS = 8;
    localparam int SIZE_DIV  = 7;
    localparam int NUM_W     = COORD_BITS + FRAC_BITS;
    localparam int ES_W      = COORD_BITS + 6;

    // Reciprocal for the divide-by-seven unit; quotient estimate is exact or one low
    localparam int DIV_SHIFT = NUM_W + 1;
    localparam int RECIP_W   = DIV_SHIFT - 2;
    localparam longint DIV_RECIP = (64'd1 << DIV_SHIFT) / SIZE_DIV;
    localparam int PROD_W    = NUM_W + RECIP_W;

    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    // Input opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [ES_W-1:0]       es;
        logic [HITS_W-1:0]     hits;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DIV     = 6'b000010,
        S_SCAN    = 6'b000100,
        S_MERGE   = 6'b001000,
        S_FINISH  = 6'b010000,
        S_RECOUNT = 6'b100000
    } t_state;

endpackage

### src/fcmt_div7.sv
module fcmt_div7 import fcmt_pkg::*; (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    output logic [ES_W-1:0]  o_quot
);

    logic [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]  r_num;
    logic [ES_W-1:0]   q_est;
    logic [NUM_W-1:0]  q_times;
    logic [NUM_W-1:0]  rem;

    // Register the reciprocal product
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_num) * PROD_W'(DIV_RECIP);
        r_num  <= i_num;
    end

    // Correct the estimate by one compare and subtract
    always_comb begin
        q_est   = ES_W'(r_prod >> DIV_SHIFT);
        q_times = NUM_W'(({3'b000, q_est} << 3) - {3'b000, q_est});
        rem     = r_num - q_times;
        o_quot  = (rem >= NUM_W'(SIZE_DIV)) ? q_est + ES_W'(1) : q_est;
    end

endmodule

### src/finder_candidate_merge_table.sv
// Finder-pattern candidate merge table.
// Input channel (i_in_valid / o_in_stall): one item is an opcode plus a
// candidate x, y and size. Insert scans the stored entries in slot order and
// merges the candidate into the first close entry, or appends it, or drops it
// when the table is full; clear empties the table. Every item yields exactly one result on the output
// channel (o_out_valid / i_out_stall).
// Configuration (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
// confidence threshold; the block then recounts confident entries, one
// entry per cycle, before taking the next item.
// A clear goes straight to the output register. An insert scales the size,
// scans the filled slots, then appends or drops the candidate, or stops at
// the first match and writes the merged entry. The next item is taken once
// the output register is loaded and the block is idle again. The table has a
// single read port, walked one entry per cycle; the one-stage divide-by-seven
// unit is used once for the candidate and once more on a merge.
// One item is in work at a time; o_in_stall is high while it is.
// A finished result waits in the output register while the next item is
// taken; a stalled receiver only holds the block once a second result is due.
// Reset (synchronous, active low) empties the table, zeroes the threshold
// and drops any pending result.
`include "finder_candidate_merge_table_macros.svh"

module finder_candidate_merge_table import fcmt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_opcode,
    input  logic [COORD_BITS-1:0] i_cand_x,
    input  logic [COORD_BITS-1:0] i_cand_y,
    input  logic [COORD_BITS-1:0] i_cand_size,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [THR_W-1:0]      i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_merged,
    output logic [SLOT_W-1:0]     o_slot_index,
    output logic                  o_dropped,
    output logic [HITS_W-1:0]     o_slot_hits,
    output logic [OCC_W-1:0]      o_occupied,
    output logic [OCC_W-1:0]      o_confident_count
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic [CNT_W-1:0]    r_conf, n_conf;
    logic [THR_W-1:0]    r_thr, n_thr;
    logic [CNT_W-1:0]    r_issue, n_issue;
    logic [CNT_W-1:0]    r_cmp_idx;
    logic                r_cmp_vld;
    logic [COORD_BITS-1:0] r_cx, r_cy, r_cs;
    logic [ES_W-1:0]     r_fs;
    t_entry              r_new, n_new;
    logic                r_conf_up, n_conf_up;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic                r_res_merged, n_res_merged;
    logic                r_res_dropped, n_res_dropped;
    logic [IDX_W-1:0]    r_res_slot, n_res_slot;
    logic [HITS_W-1:0]   r_res_hits, n_res_hits;
    logic                r_out_valid;
    logic                r_o_merged, r_o_dropped;
    logic [SLOT_W-1:0]   r_o_slot;
    logic [HITS_W-1:0]   r_o_hits;
    logic [OCC_W-1:0]    r_o_occ, r_o_conf;

    t_entry              r_mem [TABLE_DEPTH];
    t_entry              r_rd;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    t_entry              wr_data;

    logic                idle, in_acc, cfg_acc, out_load;
    logic [COORD_BITS-1:0] dx, dy;
    logic [ES_W-1:0]     ds;
    logic                near_x, near_y, size_ok, hit;
    logic [COORD_BITS-1:0] mx, my, mw;
    logic [HITS_W-1:0]   mhits;
    logic [NUM_W-1:0]    div_num;
    logic [ES_W-1:0]     div_quot;

    assign idle        = (r_state == S_IDLE);
    assign o_in_stall  = !idle || i_cfg_valid;
    assign o_cfg_ready = idle;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_load    = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    // Shared divide-by-seven: candidate size on accept, merged size on a hit
    assign div_num = (r_state == S_SCAN) ? {mw, FRAC_BITS'(0)} : {i_cand_size, FRAC_BITS'(0)};

    fcmt_div7 u_div7 (
        .i_clk  (i_clk),
        .i_num  (div_num),
        .o_quot (div_quot)
    );

    // Table read: slot 0 while idle, then one slot per cycle while scanning or recounting
    assign rd_en   = idle || (r_state == S_SCAN) || (r_state == S_RECOUNT);
    assign rd_addr = idle ? '0 : r_issue[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Compare the candidate with the entry just read
    always_comb begin
        dx      = (r_cx > r_rd.x) ? r_cx - r_rd.x : r_rd.x - r_cx;
        dy      = (r_cy > r_rd.y) ? r_cy - r_rd.y : r_rd.y - r_cy;
        ds      = (r_fs > r_rd.es) ? r_fs - r_rd.es : r_rd.es - r_fs;
        near_x  = {dx, FRAC_BITS'(0)} < NUM_W'(r_rd.es);
        near_y  = {dy, FRAC_BITS'(0)} < NUM_W'(r_rd.es);
        size_ok = ds < (r_rd.es >> 2);
        hit     = r_cmp_vld && near_x && near_y && size_ok;
        mx      = COORD_BITS'(({1'b0, r_rd.x} + {1'b0, r_cx}) >> 1);
        my      = COORD_BITS'(({1'b0, r_rd.y} + {1'b0, r_cy}) >> 1);
        mw      = COORD_BITS'(({1'b0, r_rd.w} + {1'b0, r_cs}) >> 1);
        mhits   = (r_rd.hits == HITS_MAX) ? r_rd.hits : r_rd.hits + HITS_W'(1);
    end

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_conf        = r_conf;
        n_thr         = r_thr;
        n_issue       = r_issue + CNT_W'(1);
        n_new         = r_new;
        n_conf_up     = r_conf_up;
        n_slot        = r_slot;
        n_res_merged  = r_res_merged;
        n_res_dropped = r_res_dropped;
        n_res_slot    = r_res_slot;
        n_res_hits    = r_res_hits;
        wr_en         = 1'b0;
        wr_addr       = r_slot;
        wr_data       = r_new;
        case (r_state)
            S_IDLE: begin
                n_issue = CNT_W'(1);
                if (cfg_acc) begin
                    n_thr   = i_cfg_data;
                    n_conf  = '0;
                    n_state = S_RECOUNT;
                end else if (in_acc) begin
                    if (i_opcode == OP_CLEAR) begin
                        n_fill        = '0;
                        n_conf        = '0;
                        n_res_merged  = 1'b0;
                        n_res_dropped = 1'b0;
                        n_res_slot    = '0;
                        n_res_hits    = '0;
                        n_state       = S_FINISH;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // hold the read of slot 0 until the scaled size is known
                n_issue = r_issue;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (hit) begin
                    n_slot      = r_cmp_idx[IDX_W-1:0];
                    n_new.x     = mx;
                    n_new.y     = my;
                    n_new.w     = mw;
                    n_new.es    = '0;
                    n_new.hits  = mhits;
                    n_conf_up   = (r_rd.hits <= r_thr) && (mhits > r_thr);
                    n_state     = S_MERGE;
                end else if (!r_cmp_vld) begin
                    // end of valid entries: append or drop
                    n_res_merged = 1'b0;
                    if (r_fill < CNT_W'(TABLE_DEPTH)) begin
                        wr_en         = 1'b1;
                        wr_addr       = r_fill[IDX_W-1:0];
                        wr_data.x     = r_cx;
                        wr_data.y     = r_cy;
                        wr_data.w     = r_cs;
                        wr_data.es    = r_fs;
                        wr_data.hits  = HITS_W'(1);
                        n_fill        = r_fill + CNT_W'(1);
                        n_conf        = r_conf + CNT_W'(HITS_W'(1) > r_thr);
                        n_res_dropped = 1'b0;
                        n_res_slot    = r_fill[IDX_W-1:0];
                        n_res_hits    = HITS_W'(1);
                    end else begin
                        n_res_dropped = 1'b1;
                        n_res_slot    = '0;
                        n_res_hits    = '0;
                    end
                    n_state = S_FINISH;
                end
            end
            S_MERGE: begin
                wr_en         = 1'b1;
                wr_addr       = r_slot;
                wr_data       = r_new;
                wr_data.es    = div_quot;
                n_conf        = r_conf + CNT_W'(r_conf_up);
                n_res_merged  = 1'b1;
                n_res_dropped = 1'b0;
                n_res_slot    = r_slot;
                n_res_hits    = r_new.hits;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            S_RECOUNT: begin
                if (r_cmp_vld) begin
                    n_conf = r_conf + CNT_W'(r_rd.hits > r_thr);
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_conf      <= '0;
            r_thr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_conf  <= n_conf;
            r_thr   <= n_thr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_issue       <= n_issue;
        r_new         <= n_new;
        r_conf_up     <= n_conf_up;
        r_slot        <= n_slot;
        r_res_merged  <= n_res_merged;
        r_res_dropped <= n_res_dropped;
        r_res_slot    <= n_res_slot;
        r_res_hits    <= n_res_hits;
        if (rd_en) begin
            r_cmp_idx <= idle ? '0 : r_issue;
            r_cmp_vld <= idle ? (r_fill != '0) : (r_issue < r_fill);
        end
        if (in_acc) begin
            r_cx <= i_cand_x;
            r_cy <= i_cand_y;
            r_cs <= i_cand_size;
        end
        if (r_state == S_DIV) begin
            r_fs <= div_quot;
        end
        if (out_load) begin
            r_o_merged  <= r_res_merged;
            r_o_dropped <= r_res_dropped;
            r_o_slot    <= SLOT_W'(r_res_slot);
            r_o_hits    <= r_res_hits;
            r_o_occ     <= OCC_W'(r_fill);
            r_o_conf    <= OCC_W'(r_conf);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_merged          = r_o_merged;
    assign o_dropped         = r_o_dropped;
    assign o_slot_index      = r_o_slot;
    assign o_slot_hits       = r_o_hits;
    assign o_occupied        = r_o_occ;
    assign o_confident_count = r_o_conf;

    `FCMT_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= CNT_W'(TABLE_DEPTH), "fill beyond table depth")
    `FCMT_ASSERT_NOW(a_conf_bound, idle, r_conf <= r_fill, "confident count above fill")
    `FCMT_ASSERT_NEXT(a_busy_after_accept, in_acc, !idle, "item accepted but sequencer idle")
    `FCMT_ASSERT_NOW(a_drop_clean, o_out_valid && o_dropped,
        !o_merged && (o_slot_hits == '0), "dropped result carries merge data")

endmodule

### tb/finder_candidate_merge_table_tb.sv
`timescale 1ns / 100ps

module finder_candidate_merge_table_tb import fcmt_pkg::*;;

    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_ITEMS  = 350;
    localparam int NUM_SEEDS    = 6;
    localparam int END_WAIT     = 40;
    localparam logic [COORD_BITS-1:0] COORD_TOP = '1;

    typedef struct packed {
        logic              merged;
        logic [SLOT_W-1:0] slot;
        logic              dropped;
        logic [HITS_W-1:0] hits;
        logic [OCC_W-1:0]  occupied;
        logic [OCC_W-1:0]  confident;
    } t_merge_result;

    // Shadow copy of the cluster table plus the queue of results it predicts
    class cluster_scoreboard;
        logic [COORD_BITS-1:0] ent_x[TABLE_DEPTH];
        logic [COORD_BITS-1:0] ent_y[TABLE_DEPTH];
        logic [COORD_BITS-1:0] ent_w[TABLE_DEPTH];
        logic [HITS_W-1:0]     ent_hits[TABLE_DEPTH];
        int unsigned           fill;
        logic [THR_W-1:0]      threshold;
        t_merge_result         pending_results[$];
        int unsigned errors, checked, n_merged, n_appended, n_dropped, n_cleared;

        function new();
            fill = 0;
            threshold = '0;
            errors = 0;
            checked = 0;
            n_merged = 0;
            n_appended = 0;
            n_dropped = 0;
            n_cleared = 0;
        endfunction

        function logic [NUM_W-1:0] fixed(logic [COORD_BITS-1:0] c);
            return {c, {FRAC_BITS{1'b0}}};
        endfunction

        function logic [NUM_W-1:0] abs_gap(logic [NUM_W-1:0] a, logic [NUM_W-1:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function logic [OCC_W-1:0] count_confident();
            logic [OCC_W-1:0] n;
            n = '0;
            for (int i = 0; i < fill; i++)
                if (ent_hits[i] > threshold)
                    n++;
            return n;
        endfunction

        function int unsigned pending_count();
            return pending_results.size();
        endfunction

        // Apply one accepted item to the shadow table and queue its result
        function void note_item(logic op, logic [COORD_BITS-1:0] cx,
                                logic [COORD_BITS-1:0] cy, logic [COORD_BITS-1:0] cs);
            t_merge_result    r;
            logic [NUM_W-1:0] fs, es;
            bit               found;
            r = '0;
            found = 1'b0;
            if (op == OP_CLEAR) begin
                fill = 0;
                n_cleared++;
            end else begin
                fs = NUM_W'(fixed(cs) / SIZE_DIV);
                // first close entry in slot order wins
                for (int i = 0; i < fill && !found; i++) begin
                    es = NUM_W'(fixed(ent_w[i]) / SIZE_DIV);
                    if (abs_gap(fixed(cx), fixed(ent_x[i])) < es &&
                        abs_gap(fixed(cy), fixed(ent_y[i])) < es &&
                        abs_gap(fs, es) < (es >> 2)) begin
                        ent_x[i] = COORD_BITS'(({1'b0, ent_x[i]} + cx) >> 1);
                        ent_y[i] = COORD_BITS'(({1'b0, ent_y[i]} + cy) >> 1);
                        ent_w[i] = COORD_BITS'(({1'b0, ent_w[i]} + cs) >> 1);
                        if (ent_hits[i] != HITS_MAX)
                            ent_hits[i]++;
                        r.merged = 1'b1;
                        r.slot = SLOT_W'(i);
                        r.hits = ent_hits[i];
                        found = 1'b1;
                        n_merged++;
                    end
                end
                // no match: append, or drop when the table is full
                if (!found) begin
                    if (fill < TABLE_DEPTH) begin
                        ent_x[fill] = cx;
                        ent_y[fill] = cy;
                        ent_w[fill] = cs;
                        ent_hits[fill] = HITS_W'(1);
                        r.slot = SLOT_W'(fill);
                        r.hits = HITS_W'(1);
                        fill++;
                        n_appended++;
                    end else begin
                        r.dropped = 1'b1;
                        n_dropped++;
                    end
                end
            end
            r.occupied = OCC_W'(fill);
            r.confident = count_confident();
            pending_results = {pending_results, r};
        endfunction

        function void compare(string name, logic [HITS_W-1:0] want, logic [HITS_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Match one result from the block against the oldest prediction
        function void check_result(t_merge_result got);
            t_merge_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, got %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare("merged", HITS_W'(want.merged), HITS_W'(got.merged));
            compare("slot_index", HITS_W'(want.slot), HITS_W'(got.slot));
            compare("dropped", HITS_W'(want.dropped), HITS_W'(got.dropped));
            compare("slot_hits", want.hits, got.hits);
            compare("occupied", HITS_W'(want.occupied), HITS_W'(got.occupied));
            compare("confident_count", HITS_W'(want.confident), HITS_W'(got.confident));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_opcode = OP_INSERT;
    logic [COORD_BITS-1:0] i_cand_x = '0;
    logic [COORD_BITS-1:0] i_cand_y = '0;
    logic [COORD_BITS-1:0] i_cand_size = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [THR_W-1:0]      i_cfg_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_merged;
    logic [SLOT_W-1:0]     o_slot_index;
    logic                  o_dropped;
    logic [HITS_W-1:0]     o_slot_hits;
    logic [OCC_W-1:0]      o_occupied;
    logic [OCC_W-1:0]      o_confident_count;

    cluster_scoreboard sb;
    int burst_left = 1;
    int stall_left = 0;
    int stall_mode = 0;
    int quiet_cycles = 0;
    int thresholds_used = 0;
    int seed_x[NUM_SEEDS];
    int seed_y[NUM_SEEDS];
    int seed_w[NUM_SEEDS];

    finder_candidate_merge_table dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_cand_x          (i_cand_x),
        .i_cand_y          (i_cand_y),
        .i_cand_size       (i_cand_size),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_merged          (o_merged),
        .o_slot_index      (o_slot_index),
        .o_dropped         (o_dropped),
        .o_slot_hits       (o_slot_hits),
        .o_occupied        (o_occupied),
        .o_confident_count (o_confident_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: free runs, light and heavy random stalls, and solid stalls
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 40);
        end
        stall_left--;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= 1'b1;
        endcase
    end

    // Observe handshakes on all three channels
    always @(posedge i_clk) begin : monitor
        t_merge_result got;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_merged, o_slot_index, o_dropped, o_slot_hits,
                       o_occupied, o_confident_count};
                sb.check_result(got);
            end
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_opcode, i_cand_x, i_cand_y, i_cand_size);
            if (i_cfg_valid && o_cfg_ready)
                sb.threshold = i_cfg_data;
        end
    end

    // Abort when no channel has moved for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item, hold it until taken, then maybe end the burst
    task automatic send_item(logic op, logic [COORD_BITS-1:0] x,
                             logic [COORD_BITS-1:0] y, logic [COORD_BITS-1:0] s);
        int gap;
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_cand_x    <= x;
        i_cand_y    <= y;
        i_cand_size <= s;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // Hold off the sender until every predicted result has been taken
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        thresholds_used++;
    endtask

    function automatic logic [COORD_BITS-1:0] jitter(int centre, int span);
        int v;
        v = centre + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > COORD_TOP)
            v = COORD_TOP;
        return COORD_BITS'(v);
    endfunction

    // Pick fresh cluster centres, some of them on the edges of the frame
    function automatic void new_seeds();
        for (int k = 0; k < NUM_SEEDS; k++) begin
            case ($urandom_range(0, 7))
                0: seed_x[k] = 0;
                1: seed_x[k] = COORD_TOP;
                default: seed_x[k] = $urandom_range(0, COORD_TOP);
            endcase
            seed_y[k] = ($urandom_range(0, 7) == 0) ? COORD_TOP : $urandom_range(0, COORD_TOP);
            seed_w[k] = $urandom_range(40, COORD_TOP);
        end
    endfunction

    // Mostly candidates near cluster centres, plus noise, tiny sizes and clears
    task automatic run_random(int n);
        int pick;
        int k;
        for (int j = 0; j < n; j++) begin
            pick = $urandom_range(0, 99);
            k = $urandom_range(0, NUM_SEEDS - 1);
            if (pick < 3) begin
                send_item(OP_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
                          COORD_BITS'($urandom));
                new_seeds();
            end else if (pick < 72) begin
                send_item(OP_INSERT, jitter(seed_x[k], seed_w[k] / 16),
                          jitter(seed_y[k], seed_w[k] / 16),
                          jitter(seed_w[k], seed_w[k] / 12));
            end else if (pick < 88) begin
                send_item(OP_INSERT, COORD_BITS'($urandom), COORD_BITS'($urandom),
                          COORD_BITS'($urandom));
            end else begin
                send_item(OP_INSERT, COORD_BITS'($urandom), COORD_BITS'($urandom),
                          COORD_BITS'($urandom_range(0, 15)));
            end
            if ($urandom_range(0, 199) == 0)
                drain_results();
        end
    endtask

    initial begin
        logic [THR_W-1:0] settings[5];
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero-size entries never match, so the copy is appended
        send_item(OP_INSERT, '0, '0, '0);
        send_item(OP_INSERT, '0, '0, '0);
        // largest values, merged on repeat and on a near neighbour
        send_item(OP_INSERT, COORD_TOP, COORD_TOP, COORD_TOP);
        send_item(OP_INSERT, COORD_TOP, COORD_TOP, COORD_TOP);
        send_item(OP_INSERT, 12'd4090, 12'd4093, 12'd4000);
        // clear a populated table, then an empty one
        send_item(OP_CLEAR, COORD_TOP, '0, COORD_TOP);
        send_item(OP_CLEAR, '0, COORD_TOP, '0);
        // an offset equal to the scaled size is just too far to merge
        send_item(OP_INSERT, 12'd100, 12'd100, 12'd7);
        send_item(OP_INSERT, 12'd101, 12'd100, 12'd7);
        // fill the table, overflow it, then merge into a full table
        for (int j = 0; j < TABLE_DEPTH - 2; j++)
            send_item(OP_INSERT, COORD_BITS'(j * 3), COORD_BITS'(j * 5), '0);
        send_item(OP_INSERT, 12'd2000, 12'd2000, 12'd300);
        send_item(OP_INSERT, 12'd100, 12'd100, 12'd7);
        send_item(OP_CLEAR, '0, '0, '0);

        // random phases, each under its own confidence threshold
        settings[0] = THR_W'(1);
        settings[1] = '1;
        settings[2] = '0;
        settings[3] = THR_W'($urandom_range(2, 6));
        settings[4] = THR_W'($urandom);
        for (int p = 0; p < 5; p++) begin
            drain_results();
            write_threshold(settings[p]);
            new_seeds();
            run_random(PHASE_ITEMS);
        end

        drain_results();
        repeat (END_WAIT) @(posedge i_clk);
        $display("Covered %0d results: %0d merged, %0d appended, %0d dropped, %0d clears",
                 sb.checked, sb.n_merged, sb.n_appended, sb.n_dropped, sb.n_cleared);
        $display("under %0d threshold settings, with random sender gaps and receiver stalls",
                 thresholds_used + 1);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
